// ----- hdl/clc_pkg.sv -----
// ----------------------------------------------------------------------------
// clc_pkg
// Shared types, character codes and helper functions for the command line
// classifier.
// ----------------------------------------------------------------------------
package clc_pkg;

	localparam int BUFFER_SIZE = 256;
	localparam int CNT_W       = $clog2(BUFFER_SIZE + 1);
	localparam int PREFIX_LEN  = 5;
	localparam int IDX_W       = 8;
	localparam int LEN_W       = 9;
	localparam int TDATA_W     = 32;

	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_BANG = 8'h21;

	localparam logic [7:0] IDN_TEXT [PREFIX_LEN] = '{8'h2A, 8'h69, 8'h64, 8'h6E, 8'h3F};

	typedef enum logic {
		KIND_CHAR  = 1'b0,
		KIND_FLUSH = 1'b1
	} clc_kind_t;

	typedef enum logic {
		REG_IDN_ENABLED    = 1'b0,
		REG_VERBOSE_ERRORS = 1'b1
	} clc_reg_t;

	typedef enum logic [1:0] {
		ST_NONE  = 2'd0,
		ST_CMD   = 2'd1,
		ST_DATA  = 2'd2,
		ST_BREAK = 2'd3
	} clc_status_t;

	typedef logic [7:0] clc_prefix_t [PREFIX_LEN];

	typedef struct packed {
		clc_status_t        status;
		logic               stored_valid;
		logic [7:0]         stored_char;
		logic [IDX_W-1:0]   stored_index;
		logic [LEN_W-1:0]   line_length;
		logic               idn_request;
		logic               buffer_full;
		logic               overflow_error;
		logic               line_cleared;
	} clc_result_t;

	function automatic logic starts_plus_plus(input clc_prefix_t p);
		return (p[0] == CH_PLUS) && (p[1] == CH_PLUS);
	endfunction

	// letters of the query text match in either case
	function automatic logic starts_idn(input clc_prefix_t p);
		logic       hit;
		logic [7:0] b;
		hit = 1'b1;
		for (int i = 0; i < PREFIX_LEN; i++) begin
			b = p[i];
			if (IDN_TEXT[i] >= 8'h61 && IDN_TEXT[i] <= 8'h7A)
				b = b | 8'h20;
			if (b != IDN_TEXT[i])
				hit = 1'b0;
		end
		return hit;
	endfunction

endpackage

// ----- hdl/command_line_classifier.sv -----
// ----------------------------------------------------------------------------
// command_line_classifier
// Sorts a stream of serial characters into command, break, identity query
// and data lines, reporting every stored byte with its position.
// ----------------------------------------------------------------------------
// channel   dir  tdata                               tuser
// s_*       in   char_in[7:0]                        kind
// m_*       out  stored_valid .. line_cleared (30b)  status[1:0]
// cfg_*     in   register write, index 0..1          -
//
// one beat is accepted per cycle while s_tready is high; its result is registered into the output buffer
// line state updates in the cycle of acceptance, so back-to-back beats chain
// a two-entry output buffer keeps s_tready high while one result waits
// s_tready is low only while both output entries hold unsent results
// arst_n clears line state, configuration and the output buffer
// ----------------------------------------------------------------------------
module command_line_classifier import clc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,    // char_in[7:0]
	input  logic               s_tuser,    // kind
	output logic               m_tvalid,
	input  logic               m_tready,
	// stored_valid, stored_char[7:0], stored_index[7:0], line_length[8:0],
	// idn_request, buffer_full, overflow_error, line_cleared, zero pad
	output logic [TDATA_W-1:0] m_tdata,
	output logic [1:0]         m_tuser,    // status[1:0]
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic               cfg_wdata
);

	logic [CNT_W-1:0] fill_q, fill_n;
	clc_prefix_t      prefix_q, prefix_n;
	logic             esc_q, esc_n;
	logic             plus_q, plus_n;
	logic             idn_en_q, verbose_q;

	clc_result_t      res;
	clc_result_t      head_q, skid_q;
	logic             head_v_q, skid_v_q;
	logic             push, pop;
	logic             do_store, blank;
	logic [7:0]       c;

	assign c        = s_tdata;
	assign s_tready = !skid_v_q;
	assign push     = s_tvalid && s_tready;
	assign pop      = head_v_q && m_tready;

	always_comb begin
		fill_n   = fill_q;
		prefix_n = prefix_q;
		esc_n    = esc_q;
		plus_n   = plus_q;
		res      = '0;
		do_store = 1'b0;
		blank    = 1'b0;
		if (clc_kind_t'(s_tuser) == KIND_FLUSH) begin
			fill_n           = '0;
			prefix_n         = '{default: 8'h00};
			res.line_cleared = 1'b1;
		end else begin
			if (fill_q < CNT_W'(BUFFER_SIZE)) begin
				if (c == CH_CR || c == CH_LF) begin
					if (esc_q) begin
						do_store = 1'b1;
						esc_n    = 1'b0;
					end else if (fill_q == '0) begin
						fill_n           = '0;
						prefix_n         = '{default: 8'h00};
						res.line_cleared = 1'b1;
						blank            = 1'b1;
					end else begin
						if (fill_q > CNT_W'(2) && starts_plus_plus(prefix_q) && !plus_q) begin
							if (prefix_q[2] == CH_BANG) begin
								res.status       = ST_BREAK;
								fill_n           = '0;
								prefix_n         = '{default: 8'h00};
								res.line_cleared = 1'b1;
							end else begin
								res.status = ST_CMD;
							end
						end else if (fill_q > CNT_W'(3) && idn_en_q && starts_idn(prefix_q)) begin
							res.idn_request  = 1'b1;
							fill_n           = '0;
							prefix_n         = '{default: 8'h00};
							res.line_cleared = 1'b1;
						end else begin
							res.status = ST_DATA;
						end
						plus_n = 1'b0;
					end
				end else if (c == CH_ESC) begin
					if (esc_q) begin
						do_store = 1'b1;
						esc_n    = 1'b0;
					end else begin
						esc_n = 1'b1;
					end
				end else if (c == CH_PLUS) begin
					if (esc_q) begin
						esc_n = 1'b0;
						if (fill_q < CNT_W'(2))
							plus_n = 1'b1;
					end
					do_store = 1'b1;
				end else begin
					do_store = 1'b1;
					esc_n    = 1'b0;
				end
			end
			if (do_store) begin
				for (int i = 0; i < PREFIX_LEN; i++) begin
					if (fill_q == CNT_W'(i))
						prefix_n[i] = c;
				end
				res.stored_valid = 1'b1;
				res.stored_char  = c;
				res.stored_index = IDX_W'(fill_q);
				fill_n           = fill_q + CNT_W'(1);
			end
			if (!blank && fill_n >= CNT_W'(BUFFER_SIZE)) begin
				if (starts_plus_plus(prefix_n) && res.status == ST_NONE) begin
					res.overflow_error = verbose_q;
					fill_n             = '0;
					prefix_n           = '{default: 8'h00};
					res.line_cleared   = 1'b1;
				end else begin
					res.buffer_full = 1'b1;
					res.status      = ST_DATA;
				end
			end
		end
		res.line_length = LEN_W'(fill_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			prefix_q <= '{default: 8'h00};
			esc_q    <= 1'b0;
			plus_q   <= 1'b0;
		end else if (push) begin
			fill_q   <= fill_n;
			prefix_q <= prefix_n;
			esc_q    <= esc_n;
			plus_q   <= plus_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idn_en_q  <= 1'b0;
			verbose_q <= 1'b0;
		end else if (cfg_we) begin
			case (clc_reg_t'(cfg_addr))
				REG_IDN_ENABLED:    idn_en_q  <= cfg_wdata;
				REG_VERBOSE_ERRORS: verbose_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// two-entry output buffer: head is offered, skid catches a beat under stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				head_v_q <= 1'b1;
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (!head_v_q) begin
			head_v_q <= push;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				if (push)
					skid_q <= res;
			end else if (push) begin
				head_q <= res;
			end
		end else if (!head_v_q) begin
			if (push)
				head_q <= res;
		end else if (push) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = head_v_q;
	assign m_tuser  = head_q.status;
	assign m_tdata  = {2'b00, head_q.line_cleared, head_q.overflow_error,
		head_q.buffer_full, head_q.idn_request, head_q.line_length,
		head_q.stored_index, head_q.stored_char, head_q.stored_valid};

endmodule

// ----- hdl/clc_checker.sv -----
// ----------------------------------------------------------------------------
// clc_checker
// Port-level checks for the command line classifier, bound to the top level.
// ----------------------------------------------------------------------------
module clc_checker import clc_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tready,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [TDATA_W-1:0] m_tdata,
	input logic [1:0]         m_tuser
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed under stall");

	// input back-pressure only while results wait
	a_ready_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	// a stored byte leaves a non-empty line unless the line was cleared
	a_store_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[25:17] != '0 || m_tdata[29])
		else $error("byte stored but line empty");

	// a cleared line reports zero length
	a_clear_len: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[29] |-> m_tdata[25:17] == '0)
		else $error("cleared line with nonzero length");

	// a break always clears the line
	a_break_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_BREAK |-> m_tdata[29])
		else $error("break without line clear");

endmodule

bind command_line_classifier clc_checker u_clc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
